// ----- rtl/core/mep_pkg.sv -----
// types and constants shared by the mandelbrot escape pixel block
`timescale 1ns / 1ps

package mep_pkg;

  // coordinate format: signed, 28 fraction bits
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = COORD_BITS - 4;
  localparam int STEP_BITS  = COORD_BITS - 1;
  localparam int PIX_BITS   = 10;
  localparam int COUNT_BITS = 16;
  localparam int COLOUR_BITS = 8;

  // working width of c and u: origin plus 1023 steps, plus one folded square
  localparam int VAL_W  = COORD_BITS + PIX_BITS + 1;
  // shared multiplier operand and product widths
  localparam int MUL_W  = COORD_BITS;
  localparam int PROD_W = 2 * MUL_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN   = 3'd0,
    REG_Y_ORIGIN   = 3'd1,
    REG_X_STEP     = 3'd2,
    REG_Y_STEP     = 3'd3,
    REG_ITER_LIMIT = 3'd4,
    REG_BG_RED     = 3'd5,
    REG_BG_GREEN   = 3'd6,
    REG_BG_BLUE    = 3'd7
  } cfg_reg_t;

  // reset values of the registers
  localparam logic signed [COORD_BITS-1:0] X_ORIGIN_RST = -32'sd536870912;
  localparam logic signed [COORD_BITS-1:0] Y_ORIGIN_RST = 32'sd268435456;
  localparam logic [STEP_BITS-1:0]         X_STEP_RST   = 31'd786432;
  localparam logic [STEP_BITS-1:0]         Y_STEP_RST   = 31'd524288;
  localparam logic [COUNT_BITS-1:0]        LIMIT_RST    = 16'd256;
  localparam logic [COLOUR_BITS-1:0]       BG_RST       = 8'd0;

  // escape bounds: 2.0 on a component, 4.0 on the squared magnitude
  localparam logic signed [VAL_W-1:0]  TWO_VAL   = VAL_W'(64'sd1 <<< (FRAC_BITS + 1));
  localparam logic signed [PROD_W-1:0] FOUR_PROD = PROD_W'(64'sd1 <<< (2 * FRAC_BITS + 2));

  // colour constants
  localparam logic [COLOUR_BITS-1:0] COLOUR_FULL = 8'd255;
  localparam logic [COLOUR_BITS-1:0] COLOUR_NONE = 8'd0;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_origin;
    logic signed [COORD_BITS-1:0] y_origin;
    logic [STEP_BITS-1:0]         x_step;
    logic [STEP_BITS-1:0]         y_step;
    logic [COUNT_BITS-1:0]        iteration_limit;
    logic [COLOUR_BITS-1:0]       bg_red;
    logic [COLOUR_BITS-1:0]       bg_green;
    logic [COLOUR_BITS-1:0]       bg_blue;
  } cfg_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] column;
    logic [PIX_BITS-1:0] row;
  } in_word_t;

  typedef struct packed {
    logic [PIX_BITS-1:0]    out_column;
    logic [PIX_BITS-1:0]    out_row;
    logic [COLOUR_BITS-1:0] red;
    logic [COLOUR_BITS-1:0] green;
    logic [COLOUR_BITS-1:0] blue;
    logic [COUNT_BITS-1:0]  escape_count;
  } out_word_t;

endpackage

// ----- rtl/core/mep_stream_if.sv -----
// valid/ready stream interface carrying one word per handshake
`timescale 1ns / 1ps

interface mep_stream_if #(parameter type word_t = logic);

  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/core/mep_cfg_regs.sv -----
// configuration register file with indexed writes
`timescale 1ns / 1ps

module mep_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output mep_pkg::cfg_t                   cfg
);

  mep_pkg::cfg_t cfg_r;
  mep_pkg::cfg_t cfg_nxt;

  // write decode, each register takes the low bits it holds
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (mep_pkg::cfg_reg_t'(cfg_index))
        mep_pkg::REG_X_ORIGIN:   cfg_nxt.x_origin = $signed(cfg_wdata);
        mep_pkg::REG_Y_ORIGIN:   cfg_nxt.y_origin = $signed(cfg_wdata);
        mep_pkg::REG_X_STEP:     cfg_nxt.x_step = cfg_wdata[mep_pkg::STEP_BITS-1:0];
        mep_pkg::REG_Y_STEP:     cfg_nxt.y_step = cfg_wdata[mep_pkg::STEP_BITS-1:0];
        mep_pkg::REG_ITER_LIMIT: begin
          cfg_nxt.iteration_limit = cfg_wdata[mep_pkg::COUNT_BITS-1:0];
        end
        mep_pkg::REG_BG_RED:     begin
          cfg_nxt.bg_red = cfg_wdata[mep_pkg::COLOUR_BITS-1:0];
        end
        mep_pkg::REG_BG_GREEN:   begin
          cfg_nxt.bg_green = cfg_wdata[mep_pkg::COLOUR_BITS-1:0];
        end
        mep_pkg::REG_BG_BLUE:    begin
          cfg_nxt.bg_blue = cfg_wdata[mep_pkg::COLOUR_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin        <= mep_pkg::X_ORIGIN_RST;
      cfg_r.y_origin        <= mep_pkg::Y_ORIGIN_RST;
      cfg_r.x_step          <= mep_pkg::X_STEP_RST;
      cfg_r.y_step          <= mep_pkg::Y_STEP_RST;
      cfg_r.iteration_limit <= mep_pkg::LIMIT_RST;
      cfg_r.bg_red          <= mep_pkg::BG_RST;
      cfg_r.bg_green        <= mep_pkg::BG_RST;
      cfg_r.bg_blue         <= mep_pkg::BG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/mep_mul.sv -----
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module mep_mul (
  input  logic                                  clk,
  input  logic signed [mep_pkg::MUL_W-1:0]      mul_a,
  input  logic signed [mep_pkg::MUL_W-1:0]      mul_b,
  output logic signed [mep_pkg::PROD_W-1:0]     prod_r
);

  // one full-width product per cycle
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

// ----- rtl/core/mandelbrot_escape_pixel.sv -----
// mandelbrot escape-time pixel: sequencer and datapath around one shared multiplier
//
//  channel   direction  word                                           handshake
//  in_ch     in         column, row                                    valid/ready
//  out_ch    out        out_column, out_row, red, green, blue, count   valid/ready
//  cfg_*     in         register index, write data                     write enable only
//
// one pixel at a time: the states MAPX, MAPY and MAPC map the pixel to c, then each iteration
// runs SQR, SQI, CRS and UPD (re*re, im*im, re*im on the shared multiplier, then the update);
// the run ends in SQR when the limit or the component bound is reached, and in CRS when the
// squared magnitude passes its bound; the result then waits in FIN
// the multiplier's one product per cycle sets the pace of each iteration
// rst_n is synchronous; it clears the sequencer, the result valid and the configuration registers
// a held result does not stop the next pixel from being taken and worked on;
// only the final load waits for the result register to be free
`timescale 1ns / 1ps

module mandelbrot_escape_pixel (
  input  logic                              clk,
  input  logic                              rst_n,
  mep_stream_if.sink                        in_ch,
  mep_stream_if.source                      out_ch,
  input  logic                              cfg_we,
  input  logic [mep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MAPX = 9'b000000010,
    ST_MAPY = 9'b000000100,
    ST_MAPC = 9'b000001000,
    ST_SQR  = 9'b000010000,
    ST_SQI  = 9'b000100000,
    ST_CRS  = 9'b001000000,
    ST_UPD  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  localparam int VAL_W  = mep_pkg::VAL_W;
  localparam int PROD_W = mep_pkg::PROD_W;
  localparam int MUL_W  = mep_pkg::MUL_W;
  localparam int FRAC   = mep_pkg::FRAC_BITS;
  localparam int CNT_W  = mep_pkg::COUNT_BITS;
  localparam int G_W    = CNT_W + 2;

  mep_pkg::cfg_t cfg;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic [mep_pkg::PIX_BITS-1:0] col_r, row_r;
  logic signed [VAL_W-1:0]      cre_r, cim_r, re_r, im_r;
  logic signed [PROD_W-1:0]     acc_r;
  logic [CNT_W-1:0]             n_r;
  mep_pkg::out_word_t           out_word_r, out_word_nxt;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] mag_sum;
  logic signed [VAL_W-1:0]  cre_nxt, cim_nxt;
  logic                     mag_ok, at_limit, in_fire, out_load, bg;
  logic [G_W-1:0]           g3;

  mep_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mep_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // handshake
  assign in_ch.ready    = (state_r == ST_IDLE);
  assign in_fire        = in_ch.valid && (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_word_r;
  assign out_load       = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  // escape tests: component bound, then squared magnitude
  assign mag_ok   = (re_r >= -mep_pkg::TWO_VAL) && (re_r <= mep_pkg::TWO_VAL) &&
                    (im_r >= -mep_pkg::TWO_VAL) && (im_r <= mep_pkg::TWO_VAL);
  assign at_limit = (n_r == cfg.iteration_limit);
  assign mag_sum  = acc_r + prod_r;

  // mapping of the pixel to c
  assign cre_nxt = VAL_W'(cfg.x_origin) + $signed(prod_r[VAL_W-1:0]);
  assign cim_nxt = VAL_W'(cfg.y_origin) - $signed(prod_r[VAL_W-1:0]);

  // multiplier operand select
  always_comb begin
    unique case (state_r)
      ST_MAPX: begin
        mul_a = $signed(MUL_W'(col_r));
        mul_b = $signed(MUL_W'(cfg.x_step));
      end
      ST_MAPY: begin
        mul_a = $signed(MUL_W'(row_r));
        mul_b = $signed(MUL_W'(cfg.y_step));
      end
      ST_SQR: begin
        mul_a = re_r[MUL_W-1:0];
        mul_b = re_r[MUL_W-1:0];
      end
      ST_SQI: begin
        mul_a = im_r[MUL_W-1:0];
        mul_b = im_r[MUL_W-1:0];
      end
      default: begin
        mul_a = re_r[MUL_W-1:0];
        mul_b = im_r[MUL_W-1:0];
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_MAPX;
      ST_MAPX: state_nxt = ST_MAPY;
      ST_MAPY: state_nxt = ST_MAPC;
      ST_MAPC: state_nxt = ST_SQR;
      ST_SQR:  state_nxt = (at_limit || !mag_ok) ? ST_FIN : ST_SQI;
      ST_SQI:  state_nxt = ST_CRS;
      ST_CRS:  state_nxt = (mag_sum > mep_pkg::FOUR_PROD) ? ST_FIN : ST_UPD;
      ST_UPD:  state_nxt = ST_SQR;
      ST_FIN:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result colour
  assign bg = at_limit || (n_r == '0);
  assign g3 = G_W'(n_r) + G_W'({n_r, 1'b0});

  always_comb begin
    out_word_nxt.out_column = col_r;
    out_word_nxt.out_row    = row_r;
    if (bg) begin
      out_word_nxt.red          = cfg.bg_red;
      out_word_nxt.green        = cfg.bg_green;
      out_word_nxt.blue         = cfg.bg_blue;
      out_word_nxt.escape_count = '0;
    end else begin
      out_word_nxt.red          = mep_pkg::COLOUR_NONE;
      out_word_nxt.green        = (g3 > G_W'(mep_pkg::COLOUR_FULL)) ?
                                  mep_pkg::COLOUR_FULL : g3[mep_pkg::COLOUR_BITS-1:0];
      out_word_nxt.blue         = mep_pkg::COLOUR_FULL;
      out_word_nxt.escape_count = n_r;
    end
  end

  // result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      col_r <= in_ch.payload.column;
      row_r <= in_ch.payload.row;
    end
    if (state_r == ST_MAPY) begin
      cre_r <= cre_nxt;
      re_r  <= cre_nxt;
    end
    if (state_r == ST_MAPC) begin
      cim_r <= cim_nxt;
      im_r  <= cim_nxt;
      n_r   <= '0;
    end
    // hold re squared, then fold it into re^2 - im^2
    if (state_r == ST_SQI) begin
      acc_r <= prod_r;
    end
    if (state_r == ST_CRS) begin
      acc_r <= acc_r - prod_r;
    end
    // floor shift back to the coordinate format; 2*re*im folds into the shift
    if (state_r == ST_UPD) begin
      re_r <= VAL_W'(acc_r >>> FRAC) + cre_r;
      im_r <= VAL_W'(prod_r >>> (FRAC - 1)) + cim_r;
      n_r  <= n_r + 1'b1;
    end
    if (out_load) begin
      out_word_r <= out_word_nxt;
    end
  end

  // an update only ever follows a passed limit check
  a_upd_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (n_r < cfg.iteration_limit))
    else $error("iteration update at or beyond the limit");

  // the squared real operand stays within the component bound
  a_upd_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (re_r >= -mep_pkg::TWO_VAL) && (re_r <= mep_pkg::TWO_VAL))
    else $error("real part squared outside the escape bound");

  // an accepted word starts the mapping
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_MAPX))
    else $error("accepted word did not start the mapping");

  // a finished pixel waits only while the result register is full
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIN) && !out_valid_r) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished pixel not loaded into a free result register");

endmodule
